/* rtl/tlb_and_cow_page_manager_defines.svh */
// assertion macros for the tlb and copy-on-write page manager checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef TLB_AND_COW_PAGE_MANAGER_DEFINES_SVH
`define TLB_AND_COW_PAGE_MANAGER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define TLBC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define TLBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/tlbc_pkg.sv */
// shared types and codes of the tlb and copy-on-write page manager
// no dependencies
package tlbc_pkg;

  localparam int INDEX_BITS_DEF = 4;
  localparam int NUM_FRAMES_DEF = 128;
  localparam int NUM_PROCS_DEF  = 4;

  localparam int PFN_W = 7;
  localparam int VPN_IN_W = 8;
  localparam int PID_W = 16;

  // request codes
  typedef enum logic [2:0] {
    REQ_LOOKUP = 3'd0,
    REQ_INSERT = 3'd1,
    REQ_ALLOC  = 3'd2,
    REQ_FREE   = 3'd3,
    REQ_FAULT  = 3'd4,
    REQ_SWITCH = 3'd5
  } req_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_MISS    = 2'd1,
    ST_NOFRAME = 2'd2,
    ST_NOSLOT  = 2'd3
  } stat_e;

  // access flag codes
  localparam logic [1:0] RW_RDONLY = 2'd1;
  localparam logic [1:0] RW_WRACC  = 2'd2;
  localparam logic [1:0] RW_RDWR   = 2'd3;

  // sequencer states
  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_DISP,
    S_TSCAN,
    S_VSCAN,
    S_PTE_EV,
    S_RC_EV,
    S_FSCAN,
    S_FAULT_WR2,
    S_FORK_RD,
    S_FORK_CHK,
    S_FORK_UPD,
    S_DONE
  } fsm_e;

  typedef struct packed {
    logic [2:0]          req_type;
    logic [VPN_IN_W-1:0] vpn;
    logic [PFN_W-1:0]    pfn_in;
    logic [1:0]          rw;
    logic [PID_W-1:0]    pid;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [PFN_W-1:0] pfn_out;
    logic             forked;
  } rsp_t;

endpackage

/* rtl/tlb_and_cow_page_manager.sv */
// tlb and copy-on-write page manager: serial sequencer over page table,
// refcount and tlb memories; depends on tlbc_pkg
//
//   port        | dir | beat
//   in_*        | in  | one request (req_t), valid/stall
//   out_*       | out | one result (rsp_t), valid/stall
//
// lookup, free: one tlb entry per cycle in the tlb scan
// alloc, cow fault: one refcount per cycle in the frame scan
// fork: read, check and update steps per page entry on the single page table write port
// after reset a clearing pass over max(NUM_PROCS*2^(2*INDEX_BITS), NUM_FRAMES) entries
// in_stall_o is high in clearing and request work; a stalled result holds the next request
module tlb_and_cow_page_manager #(
  parameter int INDEX_BITS = tlbc_pkg::INDEX_BITS_DEF,
  parameter int NUM_FRAMES = tlbc_pkg::NUM_FRAMES_DEF,
  parameter int NUM_PROCS  = tlbc_pkg::NUM_PROCS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  tlbc_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output tlbc_pkg::rsp_t out_data_o
);
  import tlbc_pkg::*;

  localparam int VPN_W    = 2 * INDEX_BITS;
  localparam int NUM_VPNS = 1 << VPN_W;
  localparam int FRAME_W  = $clog2(NUM_FRAMES);
  localparam int SLOT_W   = $clog2(NUM_PROCS);
  localparam int RC_W     = $clog2(NUM_PROCS + 1);
  localparam int PT_N     = NUM_PROCS * NUM_VPNS;
  localparam int PT_AW    = SLOT_W + VPN_W;
  localparam int CLR_N    = (PT_N > NUM_FRAMES) ? PT_N : NUM_FRAMES;
  localparam int CNT_W    = $clog2(CLR_N);

  typedef struct packed {
    logic               valid;
    logic               writable;
    logic               shared;
    logic [FRAME_W-1:0] pfn;
  } pte_t;

  typedef struct packed {
    logic [VPN_W-1:0] vpn;
    logic [PFN_W-1:0] pfn;
  } tlbe_t;

  localparam logic [CNT_W-1:0] TLB_LIM = CNT_W'(NUM_VPNS - 1);
  localparam logic [CNT_W-1:0] FRM_LIM = CNT_W'(NUM_FRAMES - 1);
  localparam logic [CNT_W-1:0] CLR_LIM = CNT_W'(CLR_N - 1);

  // memories
  pte_t             pt_mem  [PT_N];
  logic [RC_W-1:0]  rc_mem  [NUM_FRAMES];
  tlbe_t            tlb_mem [NUM_VPNS];

  logic             pt_we, rc_we, tlb_we;
  logic [PT_AW-1:0] pt_waddr, pt_raddr;
  pte_t             pt_wdata, pt_rdata_q;
  logic [FRAME_W-1:0] rc_waddr, rc_raddr;
  logic [RC_W-1:0]  rc_wdata, rc_rdata_q;
  logic [VPN_W-1:0] tlb_waddr, tlb_raddr;
  tlbe_t            tlb_wdata, tlb_rdata_q;

  // state
  fsm_e             state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] tag_q, tag_d;
  logic             pend_q, pend_d;
  req_t             req_q, req_d;
  pte_t             pte_q, pte_d;
  logic [RC_W-1:0]  rc_old_q, rc_old_d;
  logic [SLOT_W-1:0] cur_q, cur_d, spare_q, spare_d;
  logic [1:0]       status_q, status_d;
  logic [PFN_W-1:0] pfn_q, pfn_d;
  logic             forked_q, forked_d;
  logic [NUM_VPNS-1:0] tlb_vld_q, tlb_vld_d;
  logic [NUM_PROCS-1:0] slot_used_q, slot_used_d;
  logic [PID_W-1:0] slot_pid_q [NUM_PROCS];
  logic [PID_W-1:0] slot_pid_d [NUM_PROCS];
  logic             out_valid_q, out_load;
  rsp_t             out_q;

  // derived conditions
  logic [VPN_W-1:0] vpn_idx;
  logic [PT_AW-1:0] pt_cur_addr;
  logic             tlb_hit, tlb_end, frm_hit, frm_end, vld_free;
  logic             fault_ok, out_free;
  logic             found_any, spare_any;
  logic [SLOT_W-1:0] found_idx, spare_idx;

  assign vpn_idx     = VPN_W'(req_q.vpn);
  assign pt_cur_addr = {cur_q, vpn_idx};
  assign tlb_hit  = pend_q && tlb_vld_q[tag_q[VPN_W-1:0]] && (tlb_rdata_q.vpn == vpn_idx);
  assign tlb_end  = pend_q && (tag_q == TLB_LIM);
  assign frm_hit  = pend_q && (rc_rdata_q == '0);
  assign frm_end  = pend_q && (tag_q == FRM_LIM);
  assign vld_free = !tlb_vld_q[cnt_q[VPN_W-1:0]];
  assign fault_ok = pt_rdata_q.valid && pt_rdata_q.shared && !pt_rdata_q.writable &&
                    (req_q.rw == RW_WRACC);
  assign out_free = !out_valid_q || !out_stall_i;

  // slot search for switch
  always_comb begin
    found_any = 1'b0;
    spare_any = 1'b0;
    found_idx = '0;
    spare_idx = '0;
    for (int s = 0; s < NUM_PROCS; s++) begin
      if (slot_used_q[s] && (slot_pid_q[s] == req_q.pid)) begin
        if (!found_any) begin
          found_any = 1'b1;
          found_idx = SLOT_W'(s);
        end
      end else if (!slot_used_q[s] && !spare_any) begin
        spare_any = 1'b1;
        spare_idx = SLOT_W'(s);
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR:  if (cnt_q == CLR_LIM) state_d = S_IDLE;
      S_IDLE: if (in_valid_i) state_d = S_DISP;
      S_DISP: begin
        unique case (req_q.req_type)
          REQ_LOOKUP: state_d = S_TSCAN;
          REQ_INSERT: state_d = S_VSCAN;
          REQ_ALLOC, REQ_FREE, REQ_FAULT: state_d = S_PTE_EV;
          REQ_SWITCH: state_d = (found_any || !spare_any) ? S_DONE : S_FORK_RD;
          default:    state_d = S_DONE;
        endcase
      end
      S_TSCAN: if (tlb_hit || tlb_end) state_d = S_DONE;
      S_VSCAN: if (vld_free || (cnt_q == TLB_LIM)) state_d = S_DONE;
      S_PTE_EV: begin
        unique case (req_q.req_type)
          REQ_ALLOC: state_d = S_FSCAN;
          REQ_FREE:  state_d = S_RC_EV;
          REQ_FAULT: state_d = fault_ok ? S_RC_EV : S_DONE;
          default:   state_d = S_DONE;
        endcase
      end
      S_RC_EV: begin
        unique case (req_q.req_type)
          REQ_FREE:  state_d = S_TSCAN;
          REQ_FAULT: state_d = (rc_rdata_q >= RC_W'(2)) ? S_FSCAN : S_DONE;
          default:   state_d = S_DONE;
        endcase
      end
      S_FSCAN: begin
        if (frm_hit) begin
          state_d = (req_q.req_type == REQ_FAULT) ? S_FAULT_WR2 : S_DONE;
        end else if (frm_end) begin
          state_d = S_DONE;
        end
      end
      S_FAULT_WR2: state_d = S_DONE;
      S_FORK_RD:   state_d = S_FORK_CHK;
      S_FORK_CHK:  state_d = S_FORK_UPD;
      S_FORK_UPD:  state_d = (cnt_q == TLB_LIM) ? S_DONE : S_FORK_RD;
      S_DONE:      if (out_free) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    pt_we     = 1'b0;
    pt_waddr  = pt_cur_addr;
    pt_wdata  = '0;
    pt_raddr  = pt_cur_addr;
    rc_we     = 1'b0;
    rc_waddr  = pte_q.pfn;
    rc_wdata  = '0;
    rc_raddr  = pt_rdata_q.pfn;
    tlb_we    = 1'b0;
    tlb_waddr = cnt_q[VPN_W-1:0];
    tlb_wdata = '{vpn: vpn_idx, pfn: req_q.pfn_in};
    tlb_raddr = cnt_q[VPN_W-1:0];
    cnt_d     = cnt_q;
    tag_d     = tag_q;
    pend_d    = pend_q;
    req_d     = req_q;
    pte_d     = pte_q;
    rc_old_d  = rc_old_q;
    cur_d     = cur_q;
    spare_d   = spare_q;
    status_d  = status_q;
    pfn_d     = pfn_q;
    forked_d  = forked_q;
    tlb_vld_d = tlb_vld_q;
    slot_used_d = slot_used_q;
    slot_pid_d  = slot_pid_q;
    out_load  = 1'b0;
    unique case (state_q)
      // zero the page table and the refcounts
      S_CLR: begin
        pt_we    = ({1'b0, cnt_q} < (CNT_W + 1)'(PT_N));
        pt_waddr = cnt_q[PT_AW-1:0];
        rc_we    = ({1'b0, cnt_q} < (CNT_W + 1)'(NUM_FRAMES));
        rc_waddr = cnt_q[FRAME_W-1:0];
        cnt_d    = (cnt_q == CLR_LIM) ? '0 : cnt_q + 1'b1;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          req_d    = in_data_i;
          status_d = ST_MISS;
          pfn_d    = '0;
          forked_d = 1'b0;
        end
      end
      // page entry read is issued here at the current address
      S_DISP: begin
        cnt_d  = '0;
        pend_d = 1'b0;
        if (req_q.req_type == REQ_SWITCH) begin
          tlb_vld_d = '0;
          if (found_any) begin
            cur_d    = found_idx;
            status_d = ST_DONE;
          end else if (!spare_any) begin
            status_d = ST_NOSLOT;
          end else begin
            spare_d = spare_idx;
          end
        end
      end
      // tlb scan for lookup and free
      S_TSCAN: begin
        if (tlb_hit) begin
          status_d = ST_DONE;
          if (req_q.req_type == REQ_LOOKUP) begin
            pfn_d = tlb_rdata_q.pfn;
          end else begin
            tlb_vld_d[tag_q[VPN_W-1:0]] = 1'b0;
          end
        end else if (tlb_end) begin
          status_d = (req_q.req_type == REQ_FREE) ? ST_DONE : ST_MISS;
        end else begin
          cnt_d  = cnt_q + 1'b1;
          tag_d  = cnt_q;
          pend_d = 1'b1;
        end
      end
      // first invalid tlb entry for insert
      S_VSCAN: begin
        if (vld_free) begin
          tlb_we = 1'b1;
          tlb_vld_d[cnt_q[VPN_W-1:0]] = 1'b1;
          status_d = ST_DONE;
        end else if (cnt_q != TLB_LIM) begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      // capture page entry, refcount read issued
      S_PTE_EV: begin
        pte_d  = pt_rdata_q;
        cnt_d  = '0;
        pend_d = 1'b0;
      end
      S_RC_EV: begin
        cnt_d  = '0;
        pend_d = 1'b0;
        if (req_q.req_type == REQ_FREE) begin
          rc_we    = pte_q.valid && (rc_rdata_q != '0);
          rc_wdata = rc_rdata_q - 1'b1;
          pt_we    = 1'b1;
        end else if (rc_rdata_q == RC_W'(1)) begin
          pt_we    = 1'b1;
          pt_wdata = '{valid: 1'b1, writable: 1'b1, shared: 1'b0, pfn: pte_q.pfn};
          status_d = ST_DONE;
        end else begin
          rc_old_d = rc_rdata_q;
        end
      end
      // lowest frame with a zero refcount
      S_FSCAN: begin
        rc_raddr = cnt_q[FRAME_W-1:0];
        if (frm_hit) begin
          rc_we    = 1'b1;
          rc_waddr = tag_q[FRAME_W-1:0];
          rc_wdata = RC_W'(1);
          pt_we    = 1'b1;
          status_d = ST_DONE;
          if (req_q.req_type == REQ_ALLOC) begin
            pt_wdata.valid    = 1'b1;
            pt_wdata.shared   = 1'b0;
            pt_wdata.pfn      = tag_q[FRAME_W-1:0];
            pt_wdata.writable = (req_q.rw == RW_RDWR) ? 1'b1 :
                                (req_q.rw == RW_RDONLY) ? 1'b0 : pte_q.writable;
            pfn_d = PFN_W'(tag_q[FRAME_W-1:0]);
          end else begin
            pt_wdata = '{valid: 1'b1, writable: 1'b1, shared: 1'b0,
                         pfn: tag_q[FRAME_W-1:0]};
          end
        end else if (frm_end) begin
          status_d = ST_NOFRAME;
        end else begin
          cnt_d  = cnt_q + 1'b1;
          tag_d  = cnt_q;
          pend_d = 1'b1;
        end
      end
      // release the shared frame after the copy
      S_FAULT_WR2: begin
        rc_we    = 1'b1;
        rc_wdata = rc_old_q - 1'b1;
      end
      S_FORK_RD: begin
        pt_raddr = {cur_q, cnt_q[VPN_W-1:0]};
      end
      // child entry written, refcount read issued
      S_FORK_CHK: begin
        pte_d    = pt_rdata_q;
        pt_we    = 1'b1;
        pt_waddr = {spare_q, cnt_q[VPN_W-1:0]};
        if (pt_rdata_q.valid) begin
          pt_wdata = pt_rdata_q;
          if (pt_rdata_q.writable) begin
            pt_wdata.writable = 1'b0;
            pt_wdata.shared   = 1'b1;
          end
        end
      end
      // parent update and refcount bump
      S_FORK_UPD: begin
        rc_we    = pte_q.valid;
        rc_wdata = rc_rdata_q + 1'b1;
        pt_we    = pte_q.valid && pte_q.writable;
        pt_waddr = {cur_q, cnt_q[VPN_W-1:0]};
        pt_wdata = '{valid: 1'b1, writable: 1'b0, shared: 1'b1, pfn: pte_q.pfn};
        if (cnt_q == TLB_LIM) begin
          slot_used_d[spare_q] = 1'b1;
          slot_pid_d[spare_q]  = req_q.pid;
          cur_d    = spare_q;
          forked_d = 1'b1;
          status_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DONE: out_load = out_free;
      default: ;
    endcase
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    if (pt_we) pt_mem[pt_waddr] <= pt_wdata;
    pt_rdata_q <= pt_mem[pt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rc_we) rc_mem[rc_waddr] <= rc_wdata;
    rc_rdata_q <= rc_mem[rc_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (tlb_we) tlb_mem[tlb_waddr] <= tlb_wdata;
    tlb_rdata_q <= tlb_mem[tlb_raddr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      cur_q       <= '0;
      tlb_vld_q   <= '0;
      slot_used_q <= NUM_PROCS'(1);
      out_valid_q <= 1'b0;
      for (int s = 0; s < NUM_PROCS; s++) slot_pid_q[s] <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      cur_q       <= cur_d;
      tlb_vld_q   <= tlb_vld_d;
      slot_used_q <= slot_used_d;
      slot_pid_q  <= slot_pid_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    tag_q    <= tag_d;
    req_q    <= req_d;
    pte_q    <= pte_d;
    rc_old_q <= rc_old_d;
    spare_q  <= spare_d;
    status_q <= status_d;
    pfn_q    <= pfn_d;
    forked_q <= forked_d;
    if (out_load) out_q <= '{status: status_q, pfn_out: pfn_q, forked: forked_q};
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* rtl/tlbc_checker.sv */
// port checker for the tlb and copy-on-write page manager, bound to the top level
// depends on tlbc_pkg and tlb_and_cow_page_manager_defines.svh
`include "tlb_and_cow_page_manager_defines.svh"

module tlbc_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input tlbc_pkg::rsp_t out_data_o
);
  import tlbc_pkg::*;

  // one request in work at a time
  `TLBC_ASSERT_NEXT(a_busy_after_beat, in_valid_i && !in_stall_o, in_stall_o, "accepted beat did not make the block busy")
  // stalled result beat holds
  `TLBC_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result changed")
  // a fork only reports success
  `TLBC_ASSERT_IMPL(a_fork_done, out_valid_o && out_data_o.forked, out_data_o.status == ST_DONE, "fork with failure status")
  // failures carry no frame
  `TLBC_ASSERT_IMPL(a_fail_pfn, out_valid_o && (out_data_o.status != ST_DONE), out_data_o.pfn_out == '0, "frame on failed result")

endmodule

bind tlb_and_cow_page_manager tlbc_checker u_tlbc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

/* dv/tlb_and_cow_page_manager_tb.sv */
// self-checking testbench for the tlb and copy-on-write page manager
// depends on tlbc_pkg and the tlb_and_cow_page_manager rtl; no other files
`timescale 1ns / 1ps

module tlb_and_cow_page_manager_tb;
  import tlbc_pkg::*;

  localparam int IDX_W      = INDEX_BITS_DEF;
  localparam int PAGES      = 1 << (2 * IDX_W);
  localparam int FRAMES     = NUM_FRAMES_DEF;
  localparam int PROCS      = NUM_PROCS_DEF;
  localparam int IDLE_LIMIT = 20000;

  // expected-result tracker with its own copy of the page manager state
  class cow_scoreboard;
    bit             pte_valid[PROCS*PAGES];
    bit             pte_wr[PROCS*PAGES];
    bit             pte_cow[PROCS*PAGES];
    bit [PFN_W-1:0] pte_pfn[PROCS*PAGES];
    int unsigned    refcnt[FRAMES];
    bit             tlb_valid[PAGES];
    bit [7:0]       tlb_vpn[PAGES];
    bit [PFN_W-1:0] tlb_pfn[PAGES];
    bit             slot_used[PROCS];
    bit [PID_W-1:0] slot_pid[PROCS];
    int             cur_slot;
    rsp_t           pending[$];
    int             mismatches;
    int             results_seen;
    int             req_count[8];
    int             status_count[4];
    int             fork_count;

    function new();
      slot_used[0] = 1'b1;
    endfunction

    function int lowest_free_frame();
      for (int f = 0; f < FRAMES; f++)
        if (refcnt[f] == 0) return f;
      return -1;
    endfunction

    // apply one accepted request beat and queue the result it must produce
    function void note_request(req_t r);
      rsp_t    res;
      int      idx, f, found, spare, base, kid;
      bit [7:0] v;
      res = '0;
      res.status = ST_MISS;
      v = r.vpn & 8'(PAGES - 1);
      idx = cur_slot * PAGES + v;
      req_count[r.req_type]++;
      case (r.req_type)
        REQ_LOOKUP: begin
          for (int i = 0; i < PAGES; i++)
            if (tlb_valid[i] && tlb_vpn[i] == v) begin
              res.status = ST_DONE;
              res.pfn_out = tlb_pfn[i];
              break;
            end
        end
        REQ_INSERT: begin
          for (int i = 0; i < PAGES; i++)
            if (!tlb_valid[i]) begin
              tlb_valid[i] = 1'b1;
              tlb_vpn[i] = v;
              tlb_pfn[i] = r.pfn_in;
              res.status = ST_DONE;
              break;
            end
        end
        REQ_ALLOC: begin
          f = lowest_free_frame();
          if (f < 0) begin
            res.status = ST_NOFRAME;
          end else begin
            pte_pfn[idx] = PFN_W'(f);
            pte_valid[idx] = 1'b1;
            pte_cow[idx] = 1'b0;
            refcnt[f]++;
            if (r.rw == RW_RDWR) pte_wr[idx] = 1'b1;
            if (r.rw == RW_RDONLY) pte_wr[idx] = 1'b0;
            res.status = ST_DONE;
            res.pfn_out = PFN_W'(f);
          end
        end
        REQ_FREE: begin
          if (pte_valid[idx] && refcnt[pte_pfn[idx]] > 0) refcnt[pte_pfn[idx]]--;
          pte_valid[idx] = 1'b0;
          pte_wr[idx] = 1'b0;
          pte_cow[idx] = 1'b0;
          pte_pfn[idx] = '0;
          for (int i = 0; i < PAGES; i++)
            if (tlb_valid[i] && tlb_vpn[i] == v) begin
              tlb_valid[i] = 1'b0;
              tlb_vpn[i] = '0;
              tlb_pfn[i] = '0;
              break;
            end
          res.status = ST_DONE;
        end
        REQ_FAULT: begin
          if (pte_valid[idx] && pte_cow[idx] && !pte_wr[idx] && r.rw == RW_WRACC) begin
            if (refcnt[pte_pfn[idx]] == 1) begin
              pte_wr[idx] = 1'b1;
              pte_cow[idx] = 1'b0;
              res.status = ST_DONE;
            end else if (refcnt[pte_pfn[idx]] >= 2) begin
              f = lowest_free_frame();
              if (f < 0) begin
                res.status = ST_NOFRAME;
              end else begin
                refcnt[pte_pfn[idx]]--;
                refcnt[f]++;
                pte_pfn[idx] = PFN_W'(f);
                pte_wr[idx] = 1'b1;
                pte_cow[idx] = 1'b0;
                res.status = ST_DONE;
              end
            end
          end
        end
        REQ_SWITCH: begin
          found = -1;
          spare = -1;
          for (int s = 0; s < PROCS; s++) begin
            if (slot_used[s] && slot_pid[s] == r.pid) begin
              if (found < 0) found = s;
            end else if (!slot_used[s] && spare < 0) begin
              spare = s;
            end
          end
          if (found >= 0) begin
            cur_slot = found;
            res.status = ST_DONE;
          end else if (spare < 0) begin
            res.status = ST_NOSLOT;
          end else begin
            // fork: child shares every valid parent page, writable ones turn cow
            base = cur_slot * PAGES;
            kid = spare * PAGES;
            for (int i = 0; i < PAGES; i++) begin
              pte_valid[kid+i] = 1'b0;
              pte_wr[kid+i] = 1'b0;
              pte_cow[kid+i] = 1'b0;
              pte_pfn[kid+i] = '0;
              if (pte_valid[base+i]) begin
                refcnt[pte_pfn[base+i]]++;
                if (pte_wr[base+i]) begin
                  pte_wr[base+i] = 1'b0;
                  pte_cow[base+i] = 1'b1;
                end
                pte_valid[kid+i] = 1'b1;
                pte_wr[kid+i] = pte_wr[base+i];
                pte_cow[kid+i] = pte_cow[base+i];
                pte_pfn[kid+i] = pte_pfn[base+i];
              end
            end
            slot_used[spare] = 1'b1;
            slot_pid[spare] = r.pid;
            cur_slot = spare;
            res.status = ST_DONE;
            res.forked = 1'b1;
            fork_count++;
          end
          for (int i = 0; i < PAGES; i++) tlb_valid[i] = 1'b0;
        end
        default: ;
      endcase
      status_count[res.status]++;
      pending.push_back(res);
    endfunction

    // compare one accepted result beat with the oldest expectation
    function void check_result(rsp_t got);
      rsp_t exp_res;
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with nothing expected: %p", got);
        return;
      end
      exp_res = pending.pop_front();
      if (got.status !== exp_res.status || got.pfn_out !== exp_res.pfn_out ||
          got.forked !== exp_res.forked) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d mismatch: expected status %0d pfn %0d forked %0b,",
                   results_seen, exp_res.status, exp_res.pfn_out, exp_res.forked,
                   " got status %0d pfn %0d forked %0b",
                   got.status, got.pfn_out, got.forked);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_data;

  cow_scoreboard sb = new();
  bit calm = 1'b0;
  int idle_cycles = 0;

  always #10 clk = ~clk;

  tlb_and_cow_page_manager DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // result side stall: short bursts mostly, a rare long one, none begins while calm
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(0, 2);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // signals are stable at the falling edge, so the next rising edge is predictable
  always @(negedge clk) begin
    if (out_valid && !out_stall) sb.check_result(out_data);
    if ((out_valid && !out_stall) || (in_valid && !in_stall) || !rst_n) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
        $display("tlb_and_cow_page_manager test failed");
        $finish;
      end
    end
  end

  // drive one request beat, wait for acceptance, then an optional gap
  task automatic send_request(req_t r);
    int gap, pick;
    in_valid <= 1'b1;
    in_data <= r;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    sb.note_request(r);
    @(posedge clk);
    pick = $urandom_range(0, 99);
    gap = (calm || pick < 55) ? 0 : (pick < 90) ? $urandom_range(1, 3)
                                                : $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_fields(logic [2:0] kind, logic [7:0] vpn, logic [6:0] pfn,
                             logic [1:0] rw, logic [15:0] pid);
    req_t r;
    r.req_type = kind;
    r.vpn = vpn;
    r.pfn_in = pfn;
    r.rw = rw;
    r.pid = pid;
    send_request(r);
  endtask

  // random request: mostly a small vpn and pid pool so hits, cow and resumes occur
  function automatic req_t random_request(bit inserts_only);
    req_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (inserts_only) r.req_type = (pick < 80) ? REQ_INSERT : REQ_LOOKUP;
    else if (pick < 20) r.req_type = REQ_LOOKUP;
    else if (pick < 35) r.req_type = REQ_INSERT;
    else if (pick < 58) r.req_type = REQ_ALLOC;
    else if (pick < 72) r.req_type = REQ_FREE;
    else if (pick < 90) r.req_type = REQ_FAULT;
    else if (pick < 97) r.req_type = REQ_SWITCH;
    else r.req_type = 3'($urandom_range(6, 7));
    r.vpn = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(0, 15));
    r.pfn_in = 7'($urandom_range(0, 127));
    r.rw = ($urandom_range(0, 1) == 0) ? RW_WRACC : 2'($urandom_range(0, 3));
    r.pid = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 65535))
                                        : 16'($urandom_range(0, 4));
    return r;
  endfunction

  initial begin
    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: misses, hits, extremes, cow paths, fork, resume, unknown codes
    send_fields(REQ_LOOKUP, 8'd3, 7'd0, RW_RDONLY, 16'd0);
    send_fields(REQ_INSERT, 8'd255, 7'd127, RW_RDONLY, 16'd0);
    send_fields(REQ_LOOKUP, 8'd255, 7'd0, RW_RDONLY, 16'd0);
    send_fields(REQ_ALLOC, 8'd1, 7'd0, RW_RDWR, 16'd0);
    send_fields(REQ_ALLOC, 8'd2, 7'd0, RW_RDONLY, 16'd0);
    send_fields(REQ_ALLOC, 8'd255, 7'd0, RW_WRACC, 16'd0);
    send_fields(REQ_FAULT, 8'd1, 7'd0, RW_WRACC, 16'd0);
    send_fields(REQ_FAULT, 8'd9, 7'd0, RW_WRACC, 16'd0);
    send_fields(REQ_SWITCH, 8'd0, 7'd0, RW_RDONLY, 16'd0);
    send_fields(REQ_SWITCH, 8'd0, 7'd0, RW_RDONLY, 16'hFFFF);
    send_fields(REQ_FAULT, 8'd1, 7'd0, RW_RDWR, 16'd0);
    send_fields(REQ_FAULT, 8'd1, 7'd0, RW_WRACC, 16'd0);
    send_fields(REQ_FAULT, 8'd1, 7'd0, RW_WRACC, 16'd0);
    send_fields(REQ_SWITCH, 8'd0, 7'd0, RW_RDONLY, 16'd0);
    send_fields(REQ_FREE, 8'd1, 7'd0, RW_RDONLY, 16'd0);
    send_fields(REQ_FREE, 8'd1, 7'd0, RW_RDONLY, 16'd0);
    send_fields(REQ_INSERT, 8'd2, 7'd5, RW_RDONLY, 16'd0);
    send_fields(REQ_FREE, 8'd2, 7'd0, RW_RDONLY, 16'd0);
    send_fields(REQ_LOOKUP, 8'd2, 7'd0, RW_RDONLY, 16'd0);
    send_fields(3'd6, 8'hAA, 7'h55, 2'd0, 16'hAAAA);
    send_fields(3'd7, 8'h55, 7'h2A, 2'd3, 16'h5555);
    send_fields(REQ_SWITCH, 8'd0, 7'd0, RW_RDONLY, 16'd1);
    send_fields(REQ_SWITCH, 8'd0, 7'd0, RW_RDONLY, 16'd2);
    send_fields(REQ_SWITCH, 8'd0, 7'd0, RW_RDONLY, 16'd3);

    // random mix, then a long insert run to fill the tlb, then more mix
    for (int n = 0; n < 1080; n++) begin
      if (n % 60 == 0) calm = ($urandom_range(0, 3) == 0);
      send_request(random_request(n >= 400 && n < 700));
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    if (sb.pending.size() != 0) sb.mismatches += sb.pending.size();

    $display("covered %0d results: lookup %0d insert %0d alloc %0d free %0d fault %0d",
             sb.results_seen, sb.req_count[0], sb.req_count[1], sb.req_count[2],
             sb.req_count[3], sb.req_count[4]);
    $display("switch %0d (forks %0d), status done/miss/noframe/noslot %0d/%0d/%0d/%0d",
             sb.req_count[5], sb.fork_count, sb.status_count[0], sb.status_count[1],
             sb.status_count[2], sb.status_count[3]);
    if (sb.mismatches == 0) begin
      $display("tlb_and_cow_page_manager test passed");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("tlb_and_cow_page_manager test failed");
    end
    $finish;
  end

endmodule
